FILE: hw/rtl/qmr_pkg.sv
// shared types, codes and helper functions for the quick-min relaxation step core
`default_nettype none

package qmr_pkg;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
        logic [31:0]        atom_mass;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [31:0]        timestep;
        logic [15:0]        step_total;
        logic               power_negative;
        logic signed [31:0] new_speed_x;
        logic signed [31:0] new_speed_y;
        logic signed [31:0] new_speed_z;
    } t_out;

    localparam logic [1:0] ACT_POWER    = 2'd0;
    localparam logic [1:0] ACT_ADJUST   = 2'd1;
    localparam logic [1:0] ACT_VELOCITY = 2'd2;

    localparam logic KIND_TIMESTEP = 1'b0;
    localparam logic KIND_VELOCITY = 1'b1;

    localparam logic [2:0] CFG_DT_START   = 3'd0;
    localparam logic [2:0] CFG_DT_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_DT_GROW    = 3'd2;
    localparam logic [2:0] CFG_DT_SHRINK  = 3'd3;
    localparam logic [2:0] CFG_MIN_STEPS  = 3'd4;
    localparam logic [2:0] CFG_DYNAMIC    = 3'd5;
    localparam logic [2:0] CFG_CONSTRAIN  = 3'd6;
    localparam logic [2:0] CFG_EQUAL_MASS = 3'd7;

    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_W   = 64;

    localparam logic [56:0] Q_CAP = 57'h100_0000_0000_0000;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic signed [31:0] sat_force(input logic signed [31:0] f,
                                                     input logic signed [31:0] o);
        logic signed [32:0] s;
        s = {f[31], f} + {o[31], o};
        if (s[32] != s[31]) begin
            sat_force = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_force = s[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_speed(input logic [57:0] m, input logic neg);
        if (neg) begin
            sat_speed = (m > 58'h8000_0000) ? 32'sh8000_0000 : (32'd0 - m[31:0]);
        end else begin
            sat_speed = (m > 58'h7FFF_FFFF) ? 32'sh7FFF_FFFF : m[31:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/qmr_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module qmr_mul
    import qmr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [MUL_A_W-1:0]   i_a,
    input  wire logic [MUL_B_W-1:0]   i_b,
    output logic                      o_done,
    output logic [MUL_P_W-1:0]        o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_P_W-1:0] r_p;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [MUL_A_W:0]   n_sum;

    always_comb begin
        n_sum = {1'b0, r_p[MUL_P_W-1:MUL_B_W]} + (r_p[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_p    <= {{MUL_A_W{1'b0}}, i_b};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= {n_sum, r_p[MUL_B_W-1:1]};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/qmr_div.sv
// bit-serial restoring divider, one quotient bit per cycle, saturating quotient
`default_nettype none

module qmr_div
    import qmr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_W-1:0]   i_hi,
    input  wire logic [DIV_W-1:0]   i_lo,
    input  wire logic [DIV_W-1:0]   i_d,
    output logic                    o_done,
    output logic [DIV_W-1:0]        o_q
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_d;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_lq;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] n_sh;
    logic             n_take;

    always_comb begin
        n_sh   = {r_rem[DIV_W-2:0], r_lq[DIV_W-1]};
        n_take = r_rem[DIV_W-1] | (n_sh >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_d   <= i_d;
                r_cnt <= '0;
                if (i_d == '0 || i_hi >= i_d) begin
                    r_lq   <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_hi;
                    r_lq   <= i_lo;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_take ? (n_sh - r_d) : n_sh;
                r_lq  <= {r_lq[DIV_W-2:0], n_take};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_lq;

endmodule

`default_nettype wire

FILE: hw/rtl/quick_min_relax_step_core.sv
// top level: sequencer for power accumulation, timestep adaptation and velocity update
// power item: three force-speed products; timestep item: at most one product;
// velocity item: six products, then per component up to two product-and-quotient passes;
// the shared bit-serial multiplier and divider do this arithmetic; one item at a time
// reset: synchronous active low, registers to defaults, timestep to dt_start, sums cleared
`default_nettype none

module quick_min_relax_step_core
    import qmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DOT  = 7'b0000010,
        S_MAG  = 7'b0000100,
        S_TMUL = 7'b0001000,
        S_TDIV = 7'b0010000,
        S_ADJ  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_dt_start, n_dt_start;
    logic [31:0]        r_limit, n_limit;
    logic [31:0]        r_grow, n_grow;
    logic [31:0]        r_shrink, n_shrink;
    logic [15:0]        r_min, n_min;
    logic               r_dyn, n_dyn;
    logic               r_con, n_con;
    logic [31:0]        r_eqm, n_eqm;
    logic [31:0]        r_dt, n_dt;
    logic [15:0]        r_step, n_step;
    logic signed [63:0] r_power, n_power;
    logic [1:0]         r_action, n_action;
    logic signed [31:0] r_f [3];
    logic signed [31:0] n_f [3];
    logic signed [31:0] r_v [3];
    logic signed [31:0] n_v [3];
    logic signed [31:0] r_nspd [3];
    logic signed [31:0] n_nspd [3];
    logic [31:0]        r_mass, n_mass;
    logic signed [63:0] r_dot, n_dot;
    logic [63:0]        r_magf, n_magf;
    logic [1:0]         r_idx, n_idx;
    logic               r_term, n_term;
    logic               r_busy, n_busy;
    logic [57:0]        r_sum, n_sum;
    logic [MUL_P_W-1:0] r_prod, n_prod;
    logic               r_neg, n_neg;
    logic               r_ovalid, n_ovalid;
    t_out               r_out, n_out;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_prod;
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_d;
    logic [DIV_W-1:0]   div_q;

    logic signed [31:0] f_sel, v_sel;
    logic signed [63:0] prod_s, dot_new;
    logic               term_on, term_done;
    logic [56:0]        term_add, q_cap;
    logic [57:0]        sum_next;
    logic               neg, do_scale;
    logic [47:0]        sc_raw;
    logic [31:0]        sc;

    qmr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    qmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_hi    ({{(DIV_W-MUL_P_W+DIV_W){1'b0}}, r_prod[MUL_P_W-1:DIV_W]}),
        .i_lo    (r_prod[DIV_W-1:0]),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign f_sel   = r_f[r_idx];
    assign v_sel   = r_v[r_idx];
    assign term_on = r_term ? (!r_dot[63] && r_dot != '0 && r_magf != '0) : (r_mass != '0);
    assign q_cap   = (div_q > {7'd0, Q_CAP}) ? Q_CAP : div_q[56:0];
    assign div_d   = r_term ? r_magf : {24'd0, r_mass, 8'd0};
    assign neg     = r_power[63];
    assign do_scale = r_dyn & (neg | (r_step > r_min));
    assign sc_raw  = mul_prod[63:16];

    always_comb begin
        n_state    = r_state;
        n_dt_start = r_dt_start;
        n_limit    = r_limit;
        n_grow     = r_grow;
        n_shrink   = r_shrink;
        n_min      = r_min;
        n_dyn      = r_dyn;
        n_con      = r_con;
        n_eqm      = r_eqm;
        n_dt       = r_dt;
        n_step     = r_step;
        n_power    = r_power;
        n_action   = r_action;
        n_f        = r_f;
        n_v        = r_v;
        n_nspd     = r_nspd;
        n_mass     = r_mass;
        n_dot      = r_dot;
        n_magf     = r_magf;
        n_idx      = r_idx;
        n_term     = r_term;
        n_busy     = r_busy;
        n_sum      = r_sum;
        n_prod     = r_prod;
        n_neg      = r_neg;
        n_ovalid   = r_ovalid & ~i_out_ready;
        n_out      = r_out;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        term_done  = 1'b0;
        term_add   = '0;
        prod_s     = '0;
        dot_new    = '0;
        sum_next   = '0;
        sc         = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action = i_in.action;
                    n_f[0]   = r_con ? sat_force(i_in.force_x, i_in.offset_x) : i_in.force_x;
                    n_f[1]   = r_con ? sat_force(i_in.force_y, i_in.offset_y) : i_in.force_y;
                    n_f[2]   = r_con ? sat_force(i_in.force_z, i_in.offset_z) : i_in.force_z;
                    n_v[0]   = i_in.speed_x;
                    n_v[1]   = i_in.speed_y;
                    n_v[2]   = i_in.speed_z;
                    n_mass   = (r_eqm != '0) ? r_eqm : i_in.atom_mass;
                    n_dot    = '0;
                    n_idx    = '0;
                    n_busy   = 1'b0;
                    case (i_in.action)
                        ACT_POWER:    n_state = S_DOT;
                        ACT_VELOCITY: n_state = S_DOT;
                        ACT_ADJUST:   n_state = S_ADJ;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_DOT: begin
                mul_a = {32'd0, mag32(f_sel)};
                mul_b = mag32(v_sel);
                if (!r_busy) begin
                    mul_start = 1'b1;
                    n_busy    = 1'b1;
                end else if (mul_done) begin
                    n_busy  = 1'b0;
                    prod_s  = (f_sel[31] ^ v_sel[31]) ? (64'd0 - mul_prod[63:0])
                                                     : mul_prod[63:0];
                    dot_new = sat_add64(r_dot, prod_s);
                    n_dot   = dot_new;
                    if (r_idx == 2'd2) begin
                        n_idx = '0;
                        if (r_action == ACT_POWER) begin
                            n_power = sat_add64(r_power, dot_new);
                            n_state = S_IDLE;
                        end else begin
                            n_magf  = '0;
                            n_state = S_MAG;
                        end
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_MAG: begin
                mul_a = {32'd0, mag32(f_sel)};
                mul_b = mag32(f_sel);
                if (!r_busy) begin
                    mul_start = 1'b1;
                    n_busy    = 1'b1;
                end else if (mul_done) begin
                    n_busy = 1'b0;
                    n_magf = r_magf + mul_prod[63:0];
                    if (r_idx == 2'd2) begin
                        n_idx   = '0;
                        n_term  = 1'b0;
                        n_sum   = '0;
                        n_state = S_TMUL;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            S_TMUL: begin
                mul_a = r_term ? r_dot : {32'd0, r_dt};
                mul_b = mag32(f_sel);
                if (!term_on) begin
                    term_done = 1'b1;
                end else if (!r_busy) begin
                    mul_start = 1'b1;
                    n_busy    = 1'b1;
                end else if (mul_done) begin
                    n_busy  = 1'b0;
                    n_prod  = mul_prod;
                    n_state = S_TDIV;
                end
            end
            S_TDIV: begin
                if (!r_busy) begin
                    div_start = 1'b1;
                    n_busy    = 1'b1;
                end else if (div_done) begin
                    n_busy    = 1'b0;
                    term_done = 1'b1;
                    term_add  = q_cap;
                end
            end
            S_ADJ: begin
                mul_a = {32'd0, r_dt};
                mul_b = neg ? r_shrink : r_grow;
                if (do_scale && !r_busy) begin
                    mul_start = 1'b1;
                    n_busy    = 1'b1;
                end else if (!do_scale || mul_done) begin
                    n_busy = 1'b0;
                    if (do_scale) begin
                        sc = (|sc_raw[47:32]) ? 32'hFFFF_FFFF : sc_raw[31:0];
                        if (!neg && sc > r_limit) begin
                            sc = r_limit;
                        end
                        n_dt = sc;
                    end
                    if (r_dyn) begin
                        n_step = neg ? 16'd0 : ((r_step == 16'hFFFF) ? r_step : r_step + 16'd1);
                    end
                    n_neg   = neg;
                    n_power = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid             = 1'b1;
                    n_out.kind           = (r_action == ACT_VELOCITY) ? KIND_VELOCITY
                                                                      : KIND_TIMESTEP;
                    n_out.timestep       = r_dt;
                    n_out.step_total     = r_step;
                    n_out.power_negative = (r_action == ACT_VELOCITY) ? 1'b0 : r_neg;
                    n_out.new_speed_x    = (r_action == ACT_VELOCITY) ? r_nspd[0] : '0;
                    n_out.new_speed_y    = (r_action == ACT_VELOCITY) ? r_nspd[1] : '0;
                    n_out.new_speed_z    = (r_action == ACT_VELOCITY) ? r_nspd[2] : '0;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (term_done) begin
            sum_next = r_sum + {1'b0, term_add};
            if (!r_term) begin
                n_term  = 1'b1;
                n_sum   = sum_next;
                n_state = S_TMUL;
            end else begin
                n_nspd[r_idx] = sat_speed(sum_next, f_sel[31]);
                n_sum         = '0;
                n_term        = 1'b0;
                if (r_idx == 2'd2) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_TMUL;
                end
            end
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DT_START: begin
                    n_dt_start = i_cfg_data;
                    n_dt       = i_cfg_data;
                end
                CFG_DT_LIMIT:   n_limit  = i_cfg_data;
                CFG_DT_GROW:    n_grow   = i_cfg_data;
                CFG_DT_SHRINK:  n_shrink = i_cfg_data;
                CFG_MIN_STEPS:  n_min    = i_cfg_data[15:0];
                CFG_DYNAMIC:    n_dyn    = i_cfg_data[0];
                CFG_CONSTRAIN:  n_con    = i_cfg_data[0];
                CFG_EQUAL_MASS: n_eqm    = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dt_start <= 32'd65536;
            r_limit    <= 32'd655360;
            r_grow     <= 32'd72089;
            r_shrink   <= 32'd32768;
            r_min      <= 16'd5;
            r_dyn      <= 1'b1;
            r_con      <= 1'b0;
            r_eqm      <= 32'd0;
            r_dt       <= 32'd65536;
            r_step     <= 16'd0;
            r_power    <= '0;
            r_idx      <= '0;
            r_term     <= 1'b0;
            r_busy     <= 1'b0;
            r_sum      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dt_start <= n_dt_start;
            r_limit    <= n_limit;
            r_grow     <= n_grow;
            r_shrink   <= n_shrink;
            r_min      <= n_min;
            r_dyn      <= n_dyn;
            r_con      <= n_con;
            r_eqm      <= n_eqm;
            r_dt       <= n_dt;
            r_step     <= n_step;
            r_power    <= n_power;
            r_idx      <= n_idx;
            r_term     <= n_term;
            r_busy     <= n_busy;
            r_sum      <= n_sum;
            r_ovalid   <= n_ovalid;
        end
        r_action <= n_action;
        r_f      <= n_f;
        r_v      <= n_v;
        r_nspd   <= n_nspd;
        r_mass   <= n_mass;
        r_dot    <= n_dot;
        r_magf   <= n_magf;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: dv/tb_quick_min_relax_step_core.sv
// testbench for the quick-min relaxation step core: self-checking against a behavioral predictor
`timescale 1ns / 100ps

module tb_quick_min_relax_step_core;
    import qmr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    quick_min_relax_step_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor copy of configuration and state
    logic [31:0] m_dt_start, m_dt_limit, m_dt_grow, m_dt_shrink, m_mass_eq;
    logic [15:0] m_min_steps, m_steps;
    logic        m_dynamic, m_constrain;
    logic [31:0] m_dt;
    logic signed [63:0] m_power;

    t_in  item_q[$];
    t_out speed_q[$];
    int   n_errors;
    int   n_sent;
    logic cfg_busy;
    logic [2:0]  cfg_idx_r;
    logic [31:0] cfg_dat_r;

    function automatic logic signed [63:0] add_sat64(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [31:0] scale_step(logic [31:0] dt, logic [31:0] fac);
        logic [63:0] p;
        p = ({32'd0, dt} * {32'd0, fac}) >> 16;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic signed [63:0] cap_signed(logic [127:0] q, logic neg);
        logic signed [63:0] v;
        if (q > (128'd1 << 56)) q = 128'd1 << 56;
        v = q[63:0];
        return neg ? -v : v;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    task automatic apply_cfg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            CFG_DT_START: begin
                m_dt_start = d;
                m_dt = d;
            end
            CFG_DT_LIMIT:   m_dt_limit = d;
            CFG_DT_GROW:    m_dt_grow = d;
            CFG_DT_SHRINK:  m_dt_shrink = d;
            CFG_MIN_STEPS:  m_min_steps = d[15:0];
            CFG_DYNAMIC:    m_dynamic = d[0];
            CFG_CONSTRAIN:  m_constrain = d[0];
            default:        m_mass_eq = d;
        endcase
    endtask

    task automatic predict_step(t_in it);
        logic signed [63:0] f[3], v[3], dot, term;
        logic [63:0] fm, magf, mass, num;
        logic [127:0] q;
        logic neg;
        t_out r;
        f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
        v[0] = it.speed_x; v[1] = it.speed_y; v[2] = it.speed_z;
        if (m_constrain) begin
            f[0] = clip32(f[0] + 64'(it.offset_x));
            f[1] = clip32(f[1] + 64'(it.offset_y));
            f[2] = clip32(f[2] + 64'(it.offset_z));
        end
        dot = 0;
        magf = 0;
        for (int i = 0; i < 3; i++) begin
            dot = add_sat64(dot, f[i] * v[i]);
            magf = magf + 64'(f[i] * f[i]);
        end
        r = '0;
        r.timestep = m_dt;
        r.step_total = m_steps;
        case (it.action)
            ACT_POWER: m_power = add_sat64(m_power, dot);
            ACT_ADJUST: begin
                neg = m_power < 0;
                if (m_dynamic) begin
                    if (neg) begin
                        m_dt = scale_step(m_dt, m_dt_shrink);
                        m_steps = 0;
                    end else begin
                        if (m_steps > m_min_steps) begin
                            m_dt = scale_step(m_dt, m_dt_grow);
                            if (m_dt > m_dt_limit) m_dt = m_dt_limit;
                        end
                        if (m_steps != 16'hFFFF) m_steps++;
                    end
                end
                m_power = 0;
                r.kind = KIND_TIMESTEP;
                r.timestep = m_dt;
                r.step_total = m_steps;
                r.power_negative = neg;
                speed_q.push_back(r);
            end
            ACT_VELOCITY: begin
                mass = (m_mass_eq != 0) ? m_mass_eq : it.atom_mass;
                r.kind = KIND_VELOCITY;
                for (int i = 0; i < 3; i++) begin
                    term = 0;
                    fm = f[i] < 0 ? -f[i] : f[i];
                    if (mass != 0) begin
                        num = {32'd0, m_dt} * fm;
                        term = cap_signed(128'(num / (mass << 8)), f[i] < 0);
                    end
                    if (dot > 0 && magf != 0) begin
                        q = (128'(dot) * 128'(fm)) / 128'(magf);
                        term = term + cap_signed(q, f[i] < 0);
                    end
                    if (i == 0) r.new_speed_x = clip32(term);
                    else if (i == 1) r.new_speed_y = clip32(term);
                    else r.new_speed_z = clip32(term);
                end
                speed_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver: bursts and gaps
    int gap_left, burst_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (i_in_valid && !o_in_ready) begin
        end else begin
            if (i_in_valid) begin
                predict_step(i_in);
                n_sent <= n_sent + 1;
            end
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (item_q.size() != 0 && !cfg_busy) begin
                i_in <= item_q.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (speed_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected item %h", o_out);
                end else begin
                    t_out e;
                    e = speed_q.pop_front();
                    if (e !== o_out) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch exp %h got %h", e, o_out);
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            i_out_ready <= (stall_phase[7:6] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // config writer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            apply_cfg(i_cfg_index, i_cfg_data);
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid && cfg_busy) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_idx_r;
            i_cfg_data <= cfg_dat_r;
        end
    end

    task automatic wait_idle();
        while (item_q.size() != 0 || i_in_valid || speed_q.size() != 0) @(posedge i_clk);
        repeat (900) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_idx_r = idx;
        cfg_dat_r = d;
        cfg_busy = 1'b1;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        cfg_busy = 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 2000000)) : 0;
            3: return $urandom_range(0, 400000);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rnd_item(logic [1:0] act);
        t_in it;
        it.action = act;
        it.force_x = rnd_word(); it.force_y = rnd_word(); it.force_z = rnd_word();
        it.offset_x = rnd_word(); it.offset_y = rnd_word(); it.offset_z = rnd_word();
        it.speed_x = rnd_word(); it.speed_y = rnd_word(); it.speed_z = rnd_word();
        case ($urandom_range(0, 3))
            0: it.atom_mass = 32'hFFFF_FFFF;
            1: it.atom_mass = $urandom_range(1, 8);
            default: it.atom_mass = $urandom;
        endcase
        return it;
    endfunction

    task automatic queue_step(int atoms);
        for (int a = 0; a < atoms; a++) item_q.push_back(rnd_item(ACT_POWER));
        item_q.push_back(rnd_item(ACT_ADJUST));
        for (int a = 0; a < atoms; a++) item_q.push_back(rnd_item(ACT_VELOCITY));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        t_in it;
        n_errors = 0;
        n_sent = 0;
        cfg_busy = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        m_dt_start = 65536; m_dt_limit = 655360; m_dt_grow = 72089; m_dt_shrink = 32768;
        m_min_steps = 5; m_dynamic = 1; m_constrain = 0; m_mass_eq = 0;
        m_dt = 65536; m_steps = 0; m_power = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every action, ignored action, zero force
        it = '0;
        it.action = ACT_VELOCITY; it.atom_mass = 1;
        item_q.push_back(it);
        it.force_x = 32'h7FFF_FFFF; it.force_y = 32'h8000_0000; it.force_z = 32'h0001_0000;
        it.speed_x = 32'h7FFF_FFFF; it.speed_y = 32'h8000_0000; it.speed_z = 32'hFFFF_FFFF;
        it.atom_mass = 32'hFFFF_FFFF;
        item_q.push_back(it);
        it.action = ACT_POWER;
        item_q.push_back(it);
        item_q.push_back(it);
        it.action = 2'd3;
        item_q.push_back(it);
        it.action = ACT_ADJUST;
        item_q.push_back(it);
        it.action = ACT_POWER; it.speed_x = 32'h8000_0000;
        item_q.push_back(it);
        it.action = ACT_ADJUST;
        item_q.push_back(it);
        for (int k = 0; k < 8; k++) item_q.push_back(it);
        wait_idle();

        // constraint and common mass, non-zero common mass replaces a zero per-atom mass
        write_reg(CFG_CONSTRAIN, 32'd1);
        write_reg(CFG_EQUAL_MASS, 32'd1);
        it.action = ACT_VELOCITY; it.offset_x = 32'h7FFF_FFFF; it.offset_y = 32'h8000_0000;
        it.atom_mass = 0;
        item_q.push_back(it);
        queue_step(3);
        wait_idle();

        // minimum steps set to the top: step counter counts, no growth
        write_reg(CFG_MIN_STEPS, 32'hFFFF);
        write_reg(CFG_CONSTRAIN, 32'd0);
        it = '0;
        it.action = ACT_ADJUST;
        for (int k = 0; k < 3; k++) item_q.push_back(it);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_DT_START, 32'hFFFF_FFFF);
                    write_reg(CFG_DT_LIMIT, 32'hFFFF_FFFF);
                    write_reg(CFG_DT_GROW, 32'hFFFF_FFFF);
                    write_reg(CFG_DT_SHRINK, 32'hFFFF_FFFF);
                    write_reg(CFG_MIN_STEPS, 32'd0);
                    write_reg(CFG_EQUAL_MASS, 32'd0);
                end
                1: begin
                    write_reg(CFG_DT_START, 32'd0);
                    write_reg(CFG_DT_LIMIT, 32'd0);
                    write_reg(CFG_DT_GROW, 32'd0);
                    write_reg(CFG_DT_SHRINK, 32'd0);
                    write_reg(CFG_DYNAMIC, 32'd0);
                    write_reg(CFG_CONSTRAIN, 32'd1);
                end
                2: begin
                    write_reg(CFG_DT_START, 32'd65536);
                    write_reg(CFG_DT_LIMIT, 32'd655360);
                    write_reg(CFG_DT_GROW, 32'd72089);
                    write_reg(CFG_DT_SHRINK, 32'd32768);
                    write_reg(CFG_MIN_STEPS, 32'd2);
                    write_reg(CFG_DYNAMIC, 32'd1);
                    write_reg(CFG_EQUAL_MASS, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(CFG_DT_START, $urandom);
                    write_reg(CFG_DT_LIMIT, $urandom);
                    write_reg(CFG_DT_GROW, $urandom_range(0, 200000));
                    write_reg(CFG_DT_SHRINK, $urandom_range(0, 70000));
                    write_reg(CFG_MIN_STEPS, $urandom_range(0, 8));
                    write_reg(CFG_DYNAMIC, $urandom_range(0, 1));
                    write_reg(CFG_CONSTRAIN, $urandom_range(0, 1));
                    write_reg(CFG_EQUAL_MASS, $urandom_range(0, 1) ? 0 : $urandom);
                end
            endcase
            for (int n = 0; n < 270; ) begin
                int atoms;
                if ($urandom_range(0, 9) == 0) begin
                    item_q.push_back(rnd_item(2'($urandom_range(0, 3))));
                    n++;
                end else begin
                    atoms = $urandom_range(1, 4);
                    queue_step(atoms);
                    n += 2 * atoms + 1;
                end
            end
            wait_idle();
        end

        if (n_errors == 0 && speed_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

endmodule
